[src/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/deq_pkg.sv]
package deq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_PUSH_BACK  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               has_element;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   // ring index: base + offset, wrapped at DEPTH (offset <= DEPTH)
   function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return ADDR_W'(sum);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [31:0] v);
      return DATA_WIDTH'(v);
   endfunction

   function automatic logic signed [31:0] from_word(input logic [DATA_WIDTH-1:0] w);
      return 32'(signed'(w));
   endfunction

endpackage

[src/deq_ram.sv]
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[src/double_ended_queue_with_dump.sv]
// Channel   Ports                           Direction  Transaction when
// request   start, busy, req_data           in         start && !busy
// response  rsp_strobe, rsp_data            out        rsp_strobe (one cycle)
//
// After its acceptance a command returns one response per queue entry (one when
// the queue ends empty); busy stays high throughout.
// The queue update and its store write happen at the accepting edge; the dump
// then reads one entry per cycle through the RAM's single registered read port.
// Reset (synchronous) empties the queue; stored words are not cleared.
// Responses cannot be stalled.
`include "assert_macros.svh"

module double_ended_queue_with_dump
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_DUMP  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              pend_elem_ff, pend_elem_in;
   logic              pend_last_ff, pend_last_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic                  idx_last;

   assign accept   = start && (state_ff == S_IDLE);
   assign full     = (occ_ff == CNT_W'(DEPTH));
   assign empty    = (occ_ff == '0);
   assign idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == occ_ff);
   assign ram_raddr = slot_add(front_ff, CNT_W'(idx_ff));

   always_comb begin
      front_in  = front_ff;
      occ_in    = occ_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = slot_add(front_ff, occ_ff);
      if (accept) begin
         status_in = ST_OK;
         unique case (req_data.mode)
            MODE_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  ram_we = 1'b1;
                  occ_in = occ_ff + CNT_W'(1);
               end
            end
            MODE_PUSH_FRONT: begin
               ram_waddr = (front_ff == '0) ? ADDR_W'(DEPTH - 1) : front_ff - ADDR_W'(1);
               if (full) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  ram_we   = 1'b1;
                  front_in = ram_waddr;
                  occ_in   = occ_ff + CNT_W'(1);
               end
            end
            MODE_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  front_in = slot_add(front_ff, CNT_W'(1));
                  occ_in   = occ_ff - CNT_W'(1);
               end
            end
            MODE_POP_BACK: begin
               if (empty) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  occ_in = occ_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_elem_in = pend_elem_ff;
      pend_last_in = pend_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            pend_in = 1'b1;
            if (empty) begin
               pend_elem_in = 1'b0;
               pend_last_in = 1'b1;
               state_in     = S_DRAIN;
            end else begin
               pend_elem_in = 1'b1;
               pend_last_in = idx_last;
               idx_in       = idx_ff + ADDR_W'(1);
               if (idx_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         front_ff  <= '0;
         occ_ff    <= '0;
         status_ff <= ST_OK;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         occ_ff    <= occ_in;
         status_ff <= status_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
      end
      pend_elem_ff <= pend_elem_in;
      pend_last_ff <= pend_last_in;
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (to_word(req_data.value)),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = pend_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.has_element = pend_elem_ff;
   assign rsp_data.element     = pend_elem_ff ? from_word(ram_rdata) : 32'sd0;
   assign rsp_data.last        = pend_last_ff;

   `ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(DEPTH))
   `ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `ASSERT_NXT(a_accept_quiet, clock, reset, start && !busy, !rsp_strobe && busy)
   `ASSERT_NXT(a_last_ends, clock, reset, rsp_strobe && rsp_data.last, !rsp_strobe && !busy)
   `ASSERT_IMP(a_empty_last, clock, reset, rsp_strobe && !rsp_data.has_element,
               rsp_data.last && empty)

endmodule
